// ===== sv/ptss_pkg.sv =====
package ptss_pkg;

  // Table geometry.
  localparam int SLOTS       = 16;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  // Opcodes of an input transaction.
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_SCHED   = 2'd1;
  localparam logic [1:0] OP_UNSCHED = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_FIRED     = 3'd0;
  localparam logic [2:0] KIND_NONE_DUE  = 3'd1;
  localparam logic [2:0] KIND_SCHEDULED = 3'd2;
  localparam logic [2:0] KIND_FULL      = 3'd3;
  localparam logic [2:0] KIND_UNSCHED   = 3'd4;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd5;
  localparam logic [2:0] KIND_CLEARED   = 3'd6;

  // Source of the slot and fire_time fields of an emitted result.
  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_IDX  = 2'd1;
  localparam logic [1:0] SRC_ID   = 2'd2;
  localparam logic [1:0] SRC_PEND = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  slot_id;
    logic [31:0] start_time;
    logic [23:0] repeat_interval;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [31:0] fire_time;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic              load;
    logic              tick_start;
    logic              scan_clr;
    logic              rd_en;
    logic [SLOT_W-1:0] idx;
    logic              fire;
    logic              alloc;
    logic              unsched;
    logic              clear_all;
    logic              emit;
    logic [2:0]        emit_kind;
    logic [1:0]        emit_src;
    logic              emit_last;
  } ptss_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       free_at_idx;
    logic       id_hit;
    logic       best_found;
    logic       out_free;
  } ptss_stat_t;

endpackage

// ===== sv/periodic_timer_slot_scheduler.sv =====
// Channel   Ports                           Moves
// input     in_valid, in_ready, in_item     one command transaction
// result    out_valid, out_ready, out_item  one result transaction
//
// One command is in flight at a time; in_ready is high only while the controller idles.
// Tick: one scan of the table per firing plus an empty one, with no empty scan once
// MAX_RESULTS firings reach the cap; each scan reads every slot through the memory read port.
// Schedule runs a free slot search; unschedule and clear do not scan.
// Synchronous reset empties the table at once; no clearing pass follows.
// A waiting result stalls the controller only when another result is ready to go.
module periodic_timer_slot_scheduler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptss_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ptss_pkg::out_item_t out_item
);
  import ptss_pkg::*;

  ptss_cmd_t  cmd;
  ptss_stat_t stat;

  ptss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptss_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== sv/ptss_dp.sv =====
module ptss_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptss_pkg::ptss_cmd_t  cmd,
  output ptss_pkg::ptss_stat_t stat,
  input  ptss_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ptss_pkg::out_item_t  out_item
);
  import ptss_pkg::*;

  logic [31:0]       start_mem [SLOTS];
  logic [23:0]       rep_mem   [SLOTS];

  logic [SLOTS-1:0]  valid_r;
  logic [SLOTS-1:0]  fired_r;
  logic [31:0]       now_r;

  logic [1:0]        op_r;
  logic [3:0]        id_r;
  logic [31:0]       start_in_r;
  logic [23:0]       rep_in_r;

  logic              rd_vld_r;
  logic [SLOT_W-1:0] rd_idx_r;
  logic [31:0]       rd_start_r;
  logic [23:0]       rd_rep_r;

  logic              best_found_r;
  logic [SLOT_W-1:0] best_idx_r;
  logic [31:0]       best_start_r;
  logic [23:0]       best_rep_r;

  logic [SLOT_W-1:0] pend_slot_r;
  logic [31:0]       pend_time_r;

  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              elig;
  logic              better;
  logic [32:0]       rearm_sum;
  logic [31:0]       rearm_start;
  logic              mem_wr;
  logic [SLOT_W-1:0] mem_wr_addr;
  logic [31:0]       mem_wr_start;
  logic              id_in_range;
  out_item_t         emit_item;

  // Candidate check for the entry whose read data is in the pipeline register.
  assign elig = rd_vld_r && valid_r[rd_idx_r] && !fired_r[rd_idx_r] &&
                (rd_start_r <= now_r);
  // Strict compare keeps the lower slot on equal start times.
  assign better = !best_found_r || (rd_start_r < best_start_r);

  assign rearm_sum   = {1'b0, best_start_r} + 33'(best_rep_r);
  assign rearm_start = rearm_sum[32] ? TIME_MAX : rearm_sum[31:0];

  assign mem_wr       = cmd.alloc || (cmd.fire && (best_rep_r != 24'd0));
  assign mem_wr_addr  = cmd.alloc ? cmd.idx : best_idx_r;
  assign mem_wr_start = cmd.alloc ? start_in_r : rearm_start;

  assign id_in_range = (32'(id_r) < 32'(SLOTS));

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      start_mem[mem_wr_addr] <= mem_wr_start;
    end
    if (cmd.alloc) begin
      rep_mem[cmd.idx] <= rep_in_r;
    end
    if (cmd.rd_en) begin
      rd_start_r <= start_mem[cmd.idx];
      rd_rep_r   <= rep_mem[cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      fired_r      <= '0;
      now_r        <= '0;
      rd_vld_r     <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      rd_idx_r <= cmd.idx;

      if (cmd.load) begin
        op_r       <= in_item.opcode;
        id_r       <= in_item.slot_id;
        start_in_r <= in_item.start_time;
        rep_in_r   <= in_item.repeat_interval;
      end

      if (cmd.tick_start) begin
        fired_r <= '0;
        if (now_r != TIME_MAX) begin
          now_r <= now_r + 32'd1;
        end
      end

      if (cmd.scan_clr) begin
        best_found_r <= 1'b0;
      end else if (elig && better) begin
        best_found_r <= 1'b1;
        best_idx_r   <= rd_idx_r;
        best_start_r <= rd_start_r;
        best_rep_r   <= rd_rep_r;
      end

      priority if (cmd.clear_all) begin
        valid_r <= '0;
      end else if (cmd.alloc) begin
        valid_r[cmd.idx] <= 1'b1;
      end else if (cmd.unsched) begin
        valid_r[SLOT_W'(id_r)] <= 1'b0;
      end else if (cmd.fire && (best_rep_r == 24'd0)) begin
        valid_r[best_idx_r] <= 1'b0;
      end

      if (cmd.fire) begin
        fired_r[best_idx_r] <= 1'b1;
        pend_slot_r         <= best_idx_r;
        pend_time_r         <= best_start_r;
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        out_item_r  <= emit_item;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    emit_item.kind      = cmd.emit_kind;
    emit_item.last      = cmd.emit_last;
    emit_item.fire_time = 32'd0;
    unique case (cmd.emit_src)
      SRC_ZERO: emit_item.slot = 4'd0;
      SRC_IDX:  emit_item.slot = 4'(cmd.idx);
      SRC_ID:   emit_item.slot = id_r;
      SRC_PEND: begin
        emit_item.slot      = 4'(pend_slot_r);
        emit_item.fire_time = pend_time_r;
      end
      default:  emit_item.slot = 4'd0;
    endcase
  end

  assign stat.op          = op_r;
  assign stat.free_at_idx = !valid_r[cmd.idx];
  assign stat.id_hit      = id_in_range && valid_r[SLOT_W'(id_r)];
  assign stat.best_found  = best_found_r;
  assign stat.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== sv/ptss_ctrl.sv =====
module ptss_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ptss_pkg::ptss_stat_t stat,
  output ptss_pkg::ptss_cmd_t  cmd
);
  import ptss_pkg::*;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_DECODE    = 4'd1;
  localparam logic [3:0] ST_SCAN      = 4'd2;
  localparam logic [3:0] ST_DRAIN     = 4'd3;
  localparam logic [3:0] ST_DECIDE    = 4'd4;
  localparam logic [3:0] ST_FINAL     = 4'd5;
  localparam logic [3:0] ST_FREE_SCAN = 4'd6;
  localparam logic [3:0] ST_FULL      = 4'd7;
  localparam logic [3:0] ST_UNSCHED   = 4'd8;
  localparam logic [3:0] ST_CLEAR     = 4'd9;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

  logic [3:0]        state_r,    state_nxt;
  logic [SLOT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]  fcnt_r,     fcnt_nxt;
  logic              pend_vld_r, pend_vld_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_idx_r <= '0;
      fcnt_r     <= '0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
      fcnt_r     <= fcnt_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    fcnt_nxt     = fcnt_r;
    pend_vld_nxt = pend_vld_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.idx      = scan_idx_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        scan_idx_nxt = '0;
        unique case (stat.op)
          OP_TICK: begin
            cmd.tick_start = 1'b1;
            cmd.scan_clr   = 1'b1;
            fcnt_nxt       = '0;
            pend_vld_nxt   = 1'b0;
            state_nxt      = ST_SCAN;
          end
          OP_SCHED:   state_nxt = ST_FREE_SCAN;
          OP_UNSCHED: state_nxt = ST_UNSCHED;
          OP_CLEAR:   state_nxt = ST_CLEAR;
          default:    state_nxt = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + SLOT_W'(1);
        end
      end
      // The last entry read is still being compared in this cycle.
      ST_DRAIN: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (stat.best_found) begin
          // A held firing goes out with last clear once another one is known.
          if (!pend_vld_r || stat.out_free) begin
            if (pend_vld_r) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = KIND_FIRED;
              cmd.emit_src  = SRC_PEND;
            end
            cmd.fire     = 1'b1;
            cmd.scan_clr = 1'b1;
            pend_vld_nxt = 1'b1;
            fcnt_nxt     = fcnt_r + CNT_W'(1);
            scan_idx_nxt = '0;
            state_nxt    = (fcnt_r == CNT_W'(MAX_RESULTS - 1)) ? ST_FINAL : ST_SCAN;
          end
        end else if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_kind = pend_vld_r ? KIND_FIRED : KIND_NONE_DUE;
          cmd.emit_src  = pend_vld_r ? SRC_PEND : SRC_ZERO;
          pend_vld_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_FINAL: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_kind = KIND_FIRED;
          cmd.emit_src  = SRC_PEND;
          pend_vld_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_FREE_SCAN: begin
        if (stat.free_at_idx) begin
          if (stat.out_free) begin
            cmd.alloc     = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.emit_kind = KIND_SCHEDULED;
            cmd.emit_src  = SRC_IDX;
            state_nxt     = ST_IDLE;
          end
        end else if (scan_idx_r == LAST_IDX) begin
          state_nxt = ST_FULL;
        end else begin
          scan_idx_nxt = scan_idx_r + SLOT_W'(1);
        end
      end
      ST_FULL: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_kind = KIND_FULL;
          cmd.emit_src  = SRC_ZERO;
          state_nxt     = ST_IDLE;
        end
      end
      ST_UNSCHED: begin
        if (stat.out_free) begin
          cmd.unsched   = stat.id_hit;
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_kind = stat.id_hit ? KIND_UNSCHED : KIND_NOT_FOUND;
          cmd.emit_src  = SRC_ID;
          state_nxt     = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (stat.out_free) begin
          cmd.clear_all = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_kind = KIND_CLEARED;
          cmd.emit_src  = SRC_ZERO;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_fire_needs_best: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fire |-> stat.best_found)
    else $error("fire issued without a due slot");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result emitted while the output register is occupied");

  a_fire_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fcnt_r) <= 32'(MAX_RESULTS))
    else $error("more firings in one tick than allowed");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_vld_r)
    else $error("returned to idle with an undelivered firing");

  a_fire_then_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fire |=> pend_vld_r)
    else $error("fired slot not held for delivery");
`endif

endmodule
